@@ hdl/ssrp_pkg.sv @@
// Shared types, constants and arithmetic helpers for the servo speed ramp block.
// No dependencies; every other file of the block imports this package.
package ssrp_pkg;

  // Channel count of the ramp engine (1 to 4; the channel field is 2 bits wide).
  localparam int unsigned CHANNELS = 3;

  localparam int unsigned CH_W     = 2;
  localparam int unsigned INV_W    = 3;
  localparam int unsigned POS_W    = 18;
  localparam int unsigned PROD_W   = 34;

  localparam logic [POS_W-1:0] FULL_MDEG  = 18'd180000;
  localparam logic [POS_W-1:0] MID_MDEG   = 18'd90000;
  localparam logic [7:0]       MAX_DEG    = 8'd180;
  localparam logic [7:0]       MID_DEG    = 8'd90;
  localparam logic [POS_W-1:0] HALF_DEG   = 18'd500;
  localparam logic [9:0]       MDEG_PER   = 10'd1000;
  localparam logic [11:0]      PULSE_MIN  = 12'd500;
  localparam logic [11:0]      PULSE_MAX  = 12'd2500;
  localparam logic [INV_W-1:0] INV_RESET  = 3'b111;

  // floor(x / 1000) = (x * 268436) >> 28, exact for x below 493447.
  localparam logic [18:0]      RND_RECIP  = 19'd268436;
  // floor(e * 2000 / 180) = (e * 1456400) >> 17, exact for e up to 326.
  localparam logic [20:0]      PULSE_RECIP = 21'd1456400;

  typedef enum logic {
    KIND_SET  = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic        kind;
    logic [1:0]  channel;
    logic [7:0]  angle;
    logic [15:0] speed_deg_per_sec;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [11:0] pulse_width_us;
    logic [7:0]  logical_angle;
    logic        moving;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET,
    ST_SCAN,
    ST_PICK,
    ST_MUL,
    ST_MOVE,
    ST_ROUND,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch;
    logic set_apply;
    logic scan;
    logic idx_inc;
    logic mul;
    logic move;
    logic round;
    logic emit;
  } ssrp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic set_result;
    logic is_tick;
    logic mask_bit;
    logic mask_empty;
  } ssrp_status_t;

  // Round millidegrees (at most 180000) to whole degrees, half up.
  function automatic logic [7:0] round_deg(logic [POS_W-1:0] pos);
    logic [POS_W-1:0] x;
    logic [36:0]      p;
    x = pos + HALF_DEG;
    p = 37'(x) * 37'(RND_RECIP);
    return p[35:28];
  endfunction

  // Pulse width in microseconds for an effective angle of 0 to 180 degrees.
  function automatic logic [11:0] pulse_of(logic [7:0] eff);
    logic [28:0] p;
    p = 29'(eff) * 29'(PULSE_RECIP);
    return PULSE_MIN + p[28:17];
  endfunction

endpackage

@@ hdl/ssrp_ctrl.sv @@
// Sequencer of the servo speed ramp block: decodes items and walks the channels.
// Depends on ssrp_pkg; drives the command struct of ssrp_datapath.
module ssrp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  input  ssrp_pkg::ssrp_status_t status_i,
  output ssrp_pkg::ssrp_cmd_t    cmd_o
);
  import ssrp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == KIND_TICK) ? ST_SCAN : ST_SET;
        end
      end
      ST_SET: begin
        state_d = status_i.set_result ? ST_EMIT : ST_IDLE;
      end
      ST_SCAN: state_d = ST_PICK;
      ST_PICK: begin
        priority if (status_i.mask_empty) begin
          state_d = ST_IDLE;
        end else if (status_i.mask_bit) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_PICK;
        end
      end
      ST_MUL:   state_d = ST_MOVE;
      ST_MOVE:  state_d = ST_ROUND;
      ST_ROUND: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = (status_i.is_tick && !status_i.mask_empty) ? ST_PICK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      ST_SET:   cmd_o.set_apply = 1'b1;
      ST_SCAN:  cmd_o.scan      = 1'b1;
      ST_PICK:  cmd_o.idx_inc   = !status_i.mask_empty && !status_i.mask_bit;
      ST_MUL:   cmd_o.mul       = 1'b1;
      ST_MOVE:  cmd_o.move      = 1'b1;
      ST_ROUND: cmd_o.round     = 1'b1;
      ST_EMIT: begin
        cmd_o.emit    = status_i.out_free;
        cmd_o.idx_inc = status_i.out_free && status_i.is_tick && !status_i.mask_empty;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hdl/ssrp_datapath.sv @@
// Channel state, ramp arithmetic and output register of the servo speed ramp block.
// Depends on ssrp_pkg; sequenced by ssrp_ctrl through the command struct.
module ssrp_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_wdata_i,
  input  ssrp_pkg::in_item_t     in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ssrp_pkg::out_item_t    out_item_o,
  input  ssrp_pkg::ssrp_cmd_t    cmd_i,
  output ssrp_pkg::ssrp_status_t status_o
);
  import ssrp_pkg::*;

  localparam logic [CH_W:0] CH_COUNT = (CH_W+1)'(CHANNELS);

  logic [INV_W-1:0] invert_q;
  logic [POS_W-1:0] pos_mem_q   [CHANNELS];
  logic [7:0]       target_q    [CHANNELS];
  logic [15:0]      speed_q     [CHANNELS];
  logic [31:0]      last_time_q [CHANNELS];

  logic [CHANNELS-1:0] mask_q;
  logic [CH_W-1:0]     idx_q;
  in_item_t            item_q;

  logic [PROD_W-1:0] prod_q;
  logic              sat_q;
  logic [POS_W-1:0]  tgt_q;
  logic [POS_W-1:0]  pos_q;
  logic              stop_q;

  logic [CH_W-1:0] res_ch_q;
  logic [7:0]      res_ang_q;
  logic            res_mov_q;
  logic            res_last_q;

  logic      out_valid_q;
  out_item_t out_q;

  // Item decode.
  logic       ch_ok;
  logic [7:0] ang_clamp;
  assign ch_ok     = {1'b0, item_q.channel} < CH_COUNT;
  assign ang_clamp = (item_q.angle > MAX_DEG) ? MAX_DEG : item_q.angle;

  // Channels due on this tick.
  logic [CHANNELS-1:0] mask_new;
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mask_new[c] = (speed_q[c] != '0) && (item_q.now_ms != last_time_q[c]);
    end
  end

  logic [31:0] elapsed;
  assign elapsed = item_q.now_ms - last_time_q[idx_q];

  // Step toward the target, stopping on reach or overshoot.
  logic [POS_W-1:0] step;
  logic [POS_W:0]   sum;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_next;
  logic             stop;
  assign pos_cur = pos_mem_q[idx_q];
  assign step    = (sat_q || prod_q > PROD_W'(FULL_MDEG)) ? FULL_MDEG : prod_q[POS_W-1:0];
  assign sum     = {1'b0, pos_cur} + {1'b0, step};

  always_comb begin
    if (pos_cur < tgt_q) begin
      stop     = sum >= {1'b0, tgt_q};
      pos_next = stop ? tgt_q : sum[POS_W-1:0];
    end else begin
      stop     = (step >= pos_cur) || ((pos_cur - step) <= tgt_q);
      pos_next = stop ? tgt_q : pos_cur - step;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  logic [3:0] inv_ext;
  logic [7:0] eff;
  assign inv_ext = {1'b0, invert_q};
  assign eff     = inv_ext[res_ch_q] ? MAX_DEG - res_ang_q : res_ang_q;

  // Control and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= INV_RESET;
      mask_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_mem_q[c]   <= MID_MDEG;
        target_q[c]    <= MID_DEG;
        speed_q[c]     <= '0;
        last_time_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      if (cmd_i.set_apply && ch_ok) begin
        target_q[item_q.channel] <= ang_clamp;
        if (item_q.speed_deg_per_sec == '0) begin
          pos_mem_q[item_q.channel] <= POS_W'(ang_clamp) * POS_W'(MDEG_PER);
          speed_q[item_q.channel]   <= '0;
        end else begin
          speed_q[item_q.channel]     <= item_q.speed_deg_per_sec;
          last_time_q[item_q.channel] <= item_q.now_ms;
        end
      end
      if (cmd_i.scan) begin
        mask_q <= mask_new;
        idx_q  <= '0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.mul) begin
        mask_q[idx_q]      <= 1'b0;
        last_time_q[idx_q] <= item_q.now_ms;
      end
      if (cmd_i.move) begin
        pos_mem_q[idx_q] <= pos_next;
        if (stop) begin
          speed_q[idx_q] <= '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(speed_q[idx_q]) * PROD_W'(elapsed[POS_W-1:0]);
      sat_q  <= |elapsed[31:POS_W];
      tgt_q  <= POS_W'(target_q[idx_q]) * POS_W'(MDEG_PER);
    end
    if (cmd_i.move) begin
      pos_q  <= pos_next;
      stop_q <= stop;
    end
    if (cmd_i.set_apply) begin
      res_ch_q   <= item_q.channel;
      res_ang_q  <= ang_clamp;
      res_mov_q  <= 1'b0;
      res_last_q <= 1'b1;
    end
    if (cmd_i.round) begin
      res_ch_q   <= idx_q;
      res_ang_q  <= round_deg(pos_q);
      res_mov_q  <= !stop_q;
      res_last_q <= mask_q == '0;
    end
    if (cmd_i.emit) begin
      out_q.out_channel    <= res_ch_q;
      out_q.pulse_width_us <= pulse_of(eff);
      out_q.logical_angle  <= res_ang_q;
      out_q.moving         <= res_mov_q;
      out_q.last           <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.out_free   = out_free;
  assign status_o.set_result = ch_ok && (item_q.speed_deg_per_sec == '0);
  assign status_o.is_tick    = item_q.kind == KIND_TICK;
  assign status_o.mask_bit   = mask_q[idx_q];
  assign status_o.mask_empty = mask_q == '0;

endmodule

@@ hdl/servo_speed_ramp_pulse.sv @@
// Top level of the multi-channel servo speed ramp: pulse widths from angle ramps.
// Depends on ssrp_pkg, ssrp_ctrl and ssrp_datapath.
//
// Usage:
//   Input beats (in_valid_i/in_ready_o, in_item_i) are either set beats, which
//   give a channel a target angle (clamped to 180) and a ramp speed, or tick
//   beats, which carry the millisecond time. A set beat with speed 0 jumps the
//   channel and yields one output beat; a set beat with a nonzero speed, or for
//   a channel beyond the channel count, yields none. A tick beat steps every
//   ramping channel whose time moved and yields one output beat per channel
//   that stepped, in channel order, with last set on the final one.
//   Output beats (out_valid_o/out_ready_i, out_item_o) carry the channel, the
//   pulse width in microseconds after inversion, the rounded angle and a moving
//   flag. cfg_we_i writes the 3-bit inversion mask; write it only while idle.
// Sequence:
//   A set beat passes the set state and, when it yields a result, the emit state,
//   which loads the output register. A tick passes the scan state and then walks
//   the channels: a pick for each channel skipped, and pick, multiply, step, round
//   and emit for each stepping channel; with no channel due it returns to idle.
//   The sequencer walks them through one shared multiply, step and round unit.
//   A new beat is taken once the previous one is done, even while its last
//   result waits.
// Reset: every channel rests at 90 degrees with no ramp, the mask reads 3'b111.
// A stalled receiver holds the output register; the walk waits in the emit
// state for as long as the register stays full.
module servo_speed_ramp_pulse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssrp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssrp_pkg::out_item_t  out_item_o
);
  import ssrp_pkg::*;

  ssrp_cmd_t    cmd;
  ssrp_status_t status;

  // Sequencer: decode the beat, walk the channels, hold on a full output.
  ssrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: channel state, ramp step, rounding and the output register.
  ssrp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("result loaded over a pending output beat");

  // The pulse width stays within the servo range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pulse_width_us >= PULSE_MIN &&
                     out_item_o.pulse_width_us <= PULSE_MAX))
    else $error("pulse width out of range");

  // Rounded angle never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.logical_angle <= MAX_DEG)
    else $error("logical angle out of range");

  // No new beat is taken while the sequencer still works on a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |=> !in_ready_o)
    else $error("input taken during a channel update");

endmodule
